FILE: rtl/core/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the positional sequence store
// Element storage geometry, request and result item formats, command codes,
// sequencer states and the memory request bundle.
// ----------------------------------------------------------------------------
package pss_pkg;

	// Storage geometry
	localparam int DEPTH  = 64;
	localparam int ELEM_W = 32;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);

	// Fixed item field widths
	localparam int CMD_W = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int CNT_W = 7;

	// Common width for position against count compares
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REM_POS  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REM_BACK = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RD_POS   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RD_BACK  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

	// Status codes
	localparam logic STS_OK   = 1'b0;
	localparam logic STS_FAIL = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic             status;
		logic [VAL_W-1:0] element;
		logic [CNT_W-1:0] count;
		logic             is_empty;
	} rsp_item_t;

	typedef struct packed {
		logic              we;
		logic [AW-1:0]     waddr;
		logic [ELEM_W-1:0] wdata;
		logic [AW-1:0]     raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CAPTURE,
		ST_SHIFT,
		ST_LAST,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/pss_ram.sv
// ----------------------------------------------------------------------------
// pss_ram: element storage
// Simple dual-port memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module pss_ram #(
	parameter int DEPTH_P = 64,
	parameter int WIDTH_P = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH_P)-1:0] waddr,
	input  logic [WIDTH_P-1:0]         wdata,
	input  logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem_q [DEPTH_P];
	logic [WIDTH_P-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data registered and available in the cycle after the address
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl: request sequencer
// Decodes one request, walks the memory one entry per cycle with a single
// address stepper to open or close a gap, and tracks the element count.
// ----------------------------------------------------------------------------
module pss_ctrl import pss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_item_t         req,
	output mem_req_t          mem_req,
	input  logic [ELEM_W-1:0] mem_rdata,
	output logic              res_valid,
	output rsp_item_t         res,
	input  logic              res_take
);

	state_t            state_q, state_d;
	logic [CW-1:0]     held_q, held_d;
	logic              ok_q, ok_d;
	logic              ins_q, ins_d;
	logic              rem_op_q, rem_op_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic [ELEM_W-1:0] val_q, val_d;
	logic [ELEM_W-1:0] elem_q, elem_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     left_q, left_d;
	logic              pend_q, pend_d;
	logic [AW-1:0]     waddr_q, waddr_d;

	logic [CMP_W-1:0]  held_x;
	logic [CMP_W-1:0]  pos_x;
	logic              full;
	logic              empty;
	logic [CW-1:0]     ipos;
	logic [63:0]       elem_wide;

	assign held_x    = CMP_W'(held_q);
	assign pos_x     = CMP_W'(req.position);
	assign full      = (held_q == CW'(DEPTH));
	assign empty     = (held_q == '0);
	assign elem_wide = 64'(elem_q);

	// State and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		ok_q     <= ok_d;
		ins_q    <= ins_d;
		rem_op_q <= rem_op_d;
		pos_q    <= pos_d;
		val_q    <= val_d;
		elem_q   <= elem_d;
		idx_q    <= idx_d;
		left_q   <= left_d;
		waddr_q  <= waddr_d;
	end

	// Next state, memory requests and result
	always_comb begin
		state_d  = state_q;
		held_d   = held_q;
		ok_d     = ok_q;
		ins_d    = ins_q;
		rem_op_d = rem_op_q;
		pos_d    = pos_q;
		val_d    = val_q;
		elem_d   = elem_q;
		idx_d    = idx_q;
		left_d   = left_q;
		pend_d   = pend_q;
		waddr_d  = waddr_q;
		ipos     = CW'(req.position);

		mem_req.we    = 1'b0;
		mem_req.waddr = waddr_q;
		mem_req.wdata = mem_rdata;
		mem_req.raddr = idx_q;

		req_stall = (state_q != ST_IDLE);
		res_valid = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ok_d     = 1'b0;
					ins_d    = 1'b0;
					rem_op_d = 1'b0;
					elem_d   = '0;
					pend_d   = 1'b0;
					val_d    = ELEM_W'(req.value);
					state_d  = ST_DONE;
					// Resolve the target position and check it
					unique case (req.command)
						CMD_INS_POS, CMD_INS_BACK: begin
							if (req.command == CMD_INS_BACK) begin
								ipos = held_q;
								ok_d = !full;
							end else begin
								ok_d = !full && (pos_x <= held_x);
							end
							ins_d = 1'b1;
						end
						CMD_REM_POS, CMD_RD_POS: begin
							ok_d     = (pos_x < held_x);
							rem_op_d = (req.command == CMD_REM_POS);
						end
						CMD_REM_BACK, CMD_RD_BACK: begin
							ipos     = held_q - CW'(1);
							ok_d     = !empty;
							rem_op_d = (req.command == CMD_REM_BACK);
						end
						CMD_CLEAR: begin
							ok_d   = 1'b1;
							held_d = '0;
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
					pos_d = AW'(ipos);
					if (ok_d && (req.command != CMD_CLEAR)) begin
						if (ins_d) begin
							// Open a gap: move entries held-1 .. pos up by one
							idx_d   = AW'(held_q - CW'(1));
							left_d  = held_q - ipos;
							state_d = (left_d != '0) ? ST_SHIFT : ST_LAST;
						end else begin
							state_d = ST_FETCH;
						end
					end
				end
			end
			ST_FETCH: begin
				mem_req.raddr = pos_q;
				state_d       = ST_CAPTURE;
			end
			ST_CAPTURE: begin
				elem_d = mem_rdata;
				if (rem_op_q) begin
					// Close the gap: move entries pos+1 .. held-1 down by one
					idx_d   = pos_q + AW'(1);
					left_d  = held_q - CW'(1) - CW'(pos_q);
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				// Retire the move read in the previous cycle
				mem_req.we = pend_q;
				if (left_q != '0) begin
					mem_req.raddr = idx_q;
					pend_d        = 1'b1;
					left_d        = left_q - CW'(1);
					if (ins_q) begin
						waddr_d = idx_q + AW'(1);
						idx_d   = idx_q - AW'(1);
					end else begin
						waddr_d = idx_q - AW'(1);
						idx_d   = idx_q + AW'(1);
					end
				end else begin
					pend_d = 1'b0;
					if (ins_q) begin
						state_d = ST_LAST;
					end else begin
						held_d  = held_q - CW'(1);
						state_d = ST_DONE;
					end
				end
			end
			ST_LAST: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				mem_req.wdata = val_q;
				held_d        = held_q + CW'(1);
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result fields
	always_comb begin
		res.status   = ok_q ? STS_OK : STS_FAIL;
		res.element  = ok_q ? elem_wide[VAL_W-1:0] : '0;
		res.count    = CNT_W'(held_q);
		res.is_empty = (held_q == '0);
	end

endmodule

FILE: rtl/core/positional_sequence_store_unit.sv
// ----------------------------------------------------------------------------
// positional_sequence_store_unit: bounded ordered sequence store
// Holds up to DEPTH elements in order and serves insert, remove, read and
// clear requests by position or at the back, one result item per request.
// ----------------------------------------------------------------------------
// The work of a request is set by the memory walk, which moves one entry
// per cycle: clear and any failing request go straight to the result, a
// read fetches and captures the element, a remove also moves the entries
// behind it down by one, and an insert moves the entries from its position
// on up by one (none at the back) and then writes the value. The store
// works on one request at a time and stalls the request channel until its
// result item has moved into the output register; the output register lets
// the next request start while that result waits. No clearing pass is
// needed after reset.
module positional_sequence_store_unit import pss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	mem_req_t          mem_req;
	logic [ELEM_W-1:0] mem_rdata;
	logic              res_valid;
	rsp_item_t         res;
	logic              res_take;
	logic              out_valid_q;
	rsp_item_t         out_q;

	pss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	pss_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (ELEM_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// Move a finished result into the output register when it is free
	assign res_take = res_valid && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload while stalled
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
